FILE: hw/rtl/vrm_pkg.sv
`timescale 1ns / 1ps
package vrm_pkg;
	localparam int DIR_FRAC = 14;
	localparam int POS_W = 16;
	localparam int DIR_W = 16;
	localparam logic [7:0] EMPTY_GLYPH = 8'd32;
	localparam logic [7:0] BORDER_GLYPH = 8'd64;
	localparam logic [9:0] EPS_RESET = 10'd10;
	localparam logic [12:0] MAX_STEP_RESET = 13'd2048;
	localparam logic [9:0] BORDER_RESET = 10'd512;
	localparam logic [15:0] ITER_RESET = 16'd4096;

	localparam logic [1:0] REG_EPSILON = 2'd0;
	localparam logic [1:0] REG_MAX_STEP = 2'd1;
	localparam logic [1:0] REG_BORDER = 2'd2;
	localparam logic [1:0] REG_ITER = 2'd3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TRACE = 1'b1;

	typedef struct packed {
		logic kind;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [3:0] cell_z;
		logic [7:0] cell_glyph;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} req_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic hit;
		logic gave_up;
	} rsp_t;

	typedef struct packed {
		logic [9:0] epsilon;
		logic [12:0] max_step;
		logic [9:0] border_half_width;
		logic [15:0] iteration_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_TEST,
		ST_AXIS,
		ST_DIV,
		ST_MOVE,
		ST_MUL,
		ST_DONE
	} state_t;

	// Divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage

FILE: hw/rtl/vrm_if.sv
`timescale 1ns / 1ps
interface vrm_req_if;
	logic valid;
	logic ready;
	vrm_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface vrm_rsp_if;
	logic valid;
	logic ready;
	vrm_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/vrm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module vrm_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input logic clk,
	input logic arst_n,
	input vrm_pkg::div_ctl_t ctl,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output vrm_pkg::div_sts_t sts,
	output logic [NUM_W-1:0] quo
);
	import vrm_pkg::*;
	localparam int CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] shifted;

	assign shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DEN_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

FILE: hw/rtl/vrm_cfg.sv
`timescale 1ns / 1ps
// APB register block
module vrm_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output vrm_pkg::cfg_t cfg
);
	import vrm_pkg::*;
	cfg_t cfg_q;
	logic [1:0] idx;
	assign idx = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.epsilon <= EPS_RESET;
			cfg_q.max_step <= MAX_STEP_RESET;
			cfg_q.border_half_width <= BORDER_RESET;
			cfg_q.iteration_limit <= ITER_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_EPSILON: cfg_q.epsilon <= pwdata[9:0];
				REG_MAX_STEP: cfg_q.max_step <= pwdata[12:0];
				REG_BORDER: cfg_q.border_half_width <= pwdata[9:0];
				REG_ITER: cfg_q.iteration_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_EPSILON: prdata = {22'd0, cfg_q.epsilon};
			REG_MAX_STEP: prdata = {19'd0, cfg_q.max_step};
			REG_BORDER: prdata = {22'd0, cfg_q.border_half_width};
			REG_ITER: prdata = {16'd0, cfg_q.iteration_limit};
			default: prdata = '0;
		endcase
	end
	assign cfg = cfg_q;
endmodule

FILE: hw/rtl/voxel_ray_march_unit.sv
`timescale 1ns / 1ps
// Voxel ray march unit.
// Requests arrive on req (valid/ready). kind 0 writes one glyph into the
// voxel store and gives no response; kind 1 traces a ray and gives exactly
// one response on rsp (glyph, hit, gave_up).
// A write lands in the store at its accepting edge;
// writes can follow back to back.
// A trace passes each visited cell through bounds check, store read and
// test, and for each march step visits each axis in turn, runs the serial
// divide for each live axis (quotient width DIV_W = FRAC_BITS+15), forms
// the advance and does three multiplies. The step count is data dependent
// and bounded by iteration_limit; the response is registered once the
// march ends.
// The single divider and the single multiplier are shared by all axes.
// Registers sit on an APB port at byte addresses 0,4,8,12.
// After reset the store is cleared to space, one entry per cycle, until
// every entry is cleared; req is not ready meanwhile.
// While rsp is stalled the response holds and no new request is taken.
module voxel_ray_march_unit #(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 16,
	parameter int FRAC_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	vrm_req_if.sink req,
	vrm_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import vrm_pkg::*;
	localparam int XB = $clog2(GRID_X);
	localparam int YB = $clog2(GRID_Y);
	localparam int ZB = $clog2(GRID_Z);
	localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = 40;
	localparam int DIV_W = FRAC_BITS + 1 + DIR_FRAC;
	localparam int MW = 34;
	localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;

	cfg_t cfg;
	vrm_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	state_t state_q, state_d;
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;
	logic [AW-1:0] clr_q;
	logic signed [PW-1:0] pos_q [3];
	logic signed [DIR_W-1:0] dir_q [3];
	logic [15:0] steps_q;
	logic [1:0] ax_q;
	logic [DIV_W-1:0] dist_q;
	logic [MW-1:0] adv_q;
	rsp_t rsp_q;
	logic rsp_v_q;

	// divider
	div_ctl_t dctl;
	div_sts_t dsts;
	logic [DIV_W-1:0] dquo;
	logic [DIV_W-1:0] dnum;
	logic [DIR_W-1:0] mag;
	vrm_div #(.NUM_W(DIV_W), .DEN_W(DIR_W)) u_div (.clk, .arst_n, .ctl(dctl),
		.num(dnum), .den(mag), .sts(dsts), .quo(dquo));

	// per-axis helpers on the selected axis
	logic signed [PW-1:0] pa;
	logic signed [DIR_W-1:0] da;
	logic [FRAC_BITS-1:0] fr;
	logic live;
	assign pa = pos_q[ax_q];
	assign da = dir_q[ax_q];
	assign mag = da[DIR_W-1] ? DIR_W'(-da) : da;
	assign fr = pa[FRAC_BITS-1:0];
	assign live = ({mag, FRAC_BITS'(0)} > {cfg.epsilon, DIR_FRAC'(0)});
	assign dnum = (da[DIR_W-1] ? DIV_W'(fr) : DIV_W'(ONE - PW'(fr))) << DIR_FRAC;

	// outside and cell address
	logic outside;
	always_comb begin
		outside = pos_q[0] < 0 || pos_q[0] >= PW'(GRID_X) * ONE ||
			pos_q[1] < 0 || pos_q[1] >= PW'(GRID_Y) * ONE ||
			pos_q[2] < 0 || pos_q[2] >= PW'(GRID_Z) * ONE;
	end
	logic [AW-1:0] cell_addr, wr_addr;
	assign cell_addr = AW'((32'(pos_q[2][FRAC_BITS +: ZB]) * GRID_Y
		+ 32'(pos_q[1][FRAC_BITS +: YB])) * GRID_X + 32'(pos_q[0][FRAC_BITS +: XB]));
	assign wr_addr = AW'((32'(req.data.cell_z) * GRID_Y + 32'(req.data.cell_y)) * GRID_X
		+ 32'(req.data.cell_x));
	logic wr_in_grid;
	assign wr_in_grid = 32'(req.data.cell_x) < GRID_X && 32'(req.data.cell_y) < GRID_Y
		&& 32'(req.data.cell_z) < GRID_Z;

	// border count
	logic border;
	always_comb begin
		logic [1:0] cnt;
		logic [FRAC_BITS:0] f, d;
		cnt = '0;
		for (int a = 0; a < 3; a++) begin
			f = {1'b0, pos_q[a][FRAC_BITS-1:0]};
			d = ({f, 1'b0} <= {ONE[FRAC_BITS:0], 1'b0} >> 0 && (f <= ONE[FRAC_BITS:0] >> 1))
				? f : ONE[FRAC_BITS:0] - f;
			if ({{(32-FRAC_BITS-1){1'b0}}, d} < 32'(cfg.border_half_width))
				cnt = cnt + 1'b1;
		end
		border = cnt[1];
	end

	// shared multiplier: adv * |dir|
	logic [MW+DIR_W-1:0] prod;
	logic [MW-1:0] move;
	assign prod = adv_q * mag;
	assign move = MW'(prod >> DIR_FRAC);

	logic accept;
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data = rsp_q;
	assign dctl.start = (state_q == ST_AXIS) && live;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept && req.data.kind == KIND_TRACE) state_d = ST_CHECK;
			ST_CHECK: state_d = outside ? ST_DONE : ST_READ;
			ST_READ: state_d = ST_TEST;
			ST_TEST: begin
				if (rd_q != EMPTY_GLYPH || steps_q >= cfg.iteration_limit) state_d = ST_DONE;
				else state_d = ST_AXIS;
			end
			ST_AXIS: state_d = live ? ST_DIV : ((ax_q == 2'd2) ? ST_MOVE : ST_AXIS);
			ST_DIV: if (dsts.done) state_d = (ax_q == 2'd2) ? ST_MOVE : ST_AXIS;
			ST_MOVE: state_d = ST_MUL;
			ST_MUL: if (ax_q == 2'd2) state_d = ST_CHECK;
			ST_DONE: if (!rsp_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
			if (state_q == ST_DONE && !rsp_v_q) rsp_v_q <= 1'b1;
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[clr_q] <= EMPTY_GLYPH;
		else if (accept && req.data.kind == KIND_WRITE && wr_in_grid)
			mem[wr_addr] <= req.data.cell_glyph;
		rd_q <= mem[cell_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pos_q[0] <= PW'(req.data.origin_x);
				pos_q[1] <= PW'(req.data.origin_y);
				pos_q[2] <= PW'(req.data.origin_z);
				dir_q[0] <= req.data.dir_x;
				dir_q[1] <= req.data.dir_y;
				dir_q[2] <= req.data.dir_z;
				steps_q <= '0;
				// keep a waiting response intact until a new request is taken
				if (accept) rsp_q <= '{glyph: EMPTY_GLYPH, hit: 1'b0, gave_up: 1'b0};
			end
			ST_TEST: begin
				ax_q <= 2'd0;
				dist_q <= DIV_W'(cfg.max_step);
				if (rd_q != EMPTY_GLYPH) begin
					rsp_q.glyph <= border ? BORDER_GLYPH : rd_q;
					rsp_q.hit <= 1'b1;
				end else if (steps_q >= cfg.iteration_limit) rsp_q.gave_up <= 1'b1;
			end
			ST_AXIS: if (!live) ax_q <= ax_q + 1'b1;
			ST_DIV: if (dsts.done) begin
				if (dquo < dist_q) dist_q <= dquo;
				ax_q <= ax_q + 1'b1;
			end
			ST_MOVE: begin
				adv_q <= MW'(dist_q) + MW'(cfg.epsilon);
				ax_q <= 2'd0;
			end
			ST_MUL: begin
				pos_q[ax_q] <= da[DIR_W-1] ? pa - PW'(move) : pa + PW'(move);
				ax_q <= ax_q + 1'b1;
				if (ax_q == 2'd2) steps_q <= steps_q + 1'b1;
			end
			default: ;
		endcase
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("response dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.hit && rsp.data.gave_up))
		else $error("hit and gave_up both set");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.start |-> !dsts.busy)
		else $error("divider restarted while busy");
endmodule
